// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros; compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)
`endif

`endif

// ===== rtl/dtws_pkg.sv =====
// ----------------------------------------------------------------------------
// dtws_pkg
// Widths, command codes, serial words and the lane type of the divider chain.
// ----------------------------------------------------------------------------
package dtws_pkg;

  localparam int WORD_W   = 16;
  localparam int FREQ_W   = 32;
  localparam int FCLAMP_W = 24;                  // 10 MHz fits in 24 bits
  localparam int MCLK_W   = 25;
  localparam int TUNE_W   = 28;
  localparam int NUM_W    = FCLAMP_W + TUNE_W;   // dividend = clamped freq << 28
  localparam int NCELL    = NUM_W;               // one restoring step per cell
  localparam int HALF_W   = 14;

  localparam logic        CMD_INIT = 1'b0;
  localparam logic        CMD_SET  = 1'b1;

  localparam logic [1:0]  WAVE_SINE   = 2'd0;
  localparam logic [1:0]  WAVE_RAMP   = 2'd1;
  localparam logic [1:0]  WAVE_SQUARE = 2'd2;

  localparam logic [WORD_W-1:0] WORD_B28     = 16'h2000;
  localparam logic [WORD_W-1:0] WORD_RESET   = 16'h0100;
  localparam logic [WORD_W-1:0] WORD_OPBITEN = 16'h0020;
  localparam logic [WORD_W-1:0] WORD_DIV2    = 16'h0008;
  localparam logic [WORD_W-1:0] WORD_MODE    = 16'h0002;
  localparam logic [WORD_W-1:0] WORD_FREQ0   = 16'h4000;

  localparam logic [FREQ_W-1:0] FREQ_MAX   = 32'd10000000;
  localparam logic [MCLK_W-1:0] MCLK_RESET = 25'd25000000;
  localparam logic [MCLK_W-1:0] MCLK_ONE   = 25'd1;

  // Words still to send after the first word of a set run.
  localparam logic [1:0]  SET_TAIL = 2'd3;

  typedef struct packed {
    logic              vld;
    logic              cmd;
    logic [1:0]        wave;
    logic [MCLK_W-1:0] rem;
    logic [NUM_W-1:0]  num;   // dividend bits shift out the top, quotient in
  } dtws_lane_t;

  function automatic logic [WORD_W-1:0] ctrl_word(input logic [1:0] wave);
    logic [WORD_W-1:0] w;
    case (wave)
      WAVE_RAMP:   w = WORD_B28 | WORD_MODE;
      WAVE_SQUARE: w = WORD_B28 | WORD_OPBITEN | WORD_DIV2;
      default:     w = WORD_B28;
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/dtws_cell.sv =====
// ----------------------------------------------------------------------------
// dtws_cell
// One restoring division step: shift in a dividend bit, subtract if it fits.
// ----------------------------------------------------------------------------
module dtws_cell (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [dtws_pkg::MCLK_W-1:0]      div,
  input  dtws_pkg::dtws_lane_t             lane_in,
  output dtws_pkg::dtws_lane_t             lane_out
);
  import dtws_pkg::*;

  logic [MCLK_W:0]   rem_sh;
  logic [MCLK_W:0]   rem_sub;
  logic              fits;
  logic [MCLK_W-1:0] rem_next;
  dtws_lane_t        lane_next;

  assign rem_sh   = {lane_in.rem, lane_in.num[NUM_W-1]};
  assign fits     = rem_sh >= {1'b0, div};
  assign rem_sub  = rem_sh - {1'b0, div};
  assign rem_next = fits ? rem_sub[MCLK_W-1:0] : rem_sh[MCLK_W-1:0];

  always_comb begin
    lane_next      = lane_in;
    lane_next.rem  = rem_next;
    lane_next.num  = {lane_in.num[NUM_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_out.vld <= 1'b0;
    end else begin
      lane_out <= lane_next;
    end
  end

endmodule

// ===== rtl/dtws_emitter.sv =====
// ----------------------------------------------------------------------------
// dtws_emitter
// Turns a finished tuning word into its run of serial words, one per cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dtws_emitter (
  input  logic                          clk,
  input  logic                          rst,
  input  dtws_pkg::dtws_lane_t          lane_in,
  output logic                          word_strobe,
  output logic [dtws_pkg::WORD_W-1:0]   spi_word,
  output logic                          last,
  output logic                          reset_pin
);
  import dtws_pkg::*;

  logic [1:0]        remain;
  logic [WORD_W-1:0] q_w1;
  logic [WORD_W-1:0] q_w2;
  logic [WORD_W-1:0] q_w3;
  logic [TUNE_W-1:0] tuning;

  assign tuning = lane_in.num[TUNE_W-1:0];

  // Control: strobe and words left in the current run.
  always_ff @(posedge clk) begin
    if (rst) begin
      word_strobe <= 1'b0;
      remain      <= 2'd0;
    end else if (lane_in.vld) begin
      word_strobe <= 1'b1;
      remain      <= (lane_in.cmd == CMD_SET) ? SET_TAIL : 2'd0;
    end else if (remain != 2'd0) begin
      word_strobe <= 1'b1;
      remain      <= remain - 2'd1;
    end else begin
      word_strobe <= 1'b0;
    end
  end

  // Payload: first word goes out at once, hold the rest.
  always_ff @(posedge clk) begin
    if (lane_in.vld) begin
      spi_word  <= WORD_B28 | WORD_RESET;
      last      <= (lane_in.cmd == CMD_INIT);
      reset_pin <= (lane_in.cmd == CMD_INIT);
      q_w1      <= WORD_FREQ0 | {{(WORD_W-HALF_W){1'b0}}, tuning[HALF_W-1:0]};
      q_w2      <= WORD_FREQ0 | {{(WORD_W-HALF_W){1'b0}}, tuning[TUNE_W-1:HALF_W]};
      q_w3      <= ctrl_word(lane_in.wave);
    end else if (remain != 2'd0) begin
      reset_pin <= 1'b0;
      case (remain)
        2'd3: begin
          spi_word <= q_w1;
          last     <= 1'b0;
        end
        2'd2: begin
          spi_word <= q_w2;
          last     <= 1'b0;
        end
        default: begin
          spi_word <= q_w3;
          last     <= 1'b1;
        end
      endcase
    end
  end

  `ASSERT_NEVER(a_run_overlap, clk, rst, lane_in.vld && remain != 2'd0)
  `ASSERT_PROP(a_run_continues, clk, rst, (remain != 2'd0) |=> word_strobe)
  `ASSERT_PROP(a_run_ends_last, clk, rst, (word_strobe && remain == 2'd0) |-> last)

endmodule

// ===== rtl/dds_tuning_word_sequencer.sv =====
// ----------------------------------------------------------------------------
// dds_tuning_word_sequencer
// Builds the serial word run for a 28-bit DDS: reset word, FREQ0 halves of
// floor(freq * 2^28 / mclk_hz) and waveform control word; init sends reset only.
// ----------------------------------------------------------------------------
//
//  channel   handshake              payload
//  -------   ---------------------  ----------------------------------
//  command   start / busy           command, freq_hz, waveform
//  config    cfg_valid / cfg_ready  mclk_hz
//  result    word_strobe            spi_word, last, reset_pin
//
// An item is taken when start is high and busy is low. A set item keeps busy
// high long enough that set runs never overlap at the result port; an init
// item leaves busy low. The rate is set by the one-word-per-cycle result port.
// The divider is a chain of 52 one-step cells; the first word of an item comes
// out of the emitter register behind the last cell, the rest on consecutive
// cycles. Synchronous reset clears busy, the chain valid bits and the strobe,
// and sets div to 25 MHz. The result side has no stall; cfg_ready is always high.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dds_tuning_word_sequencer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          command,
  input  logic [dtws_pkg::FREQ_W-1:0]   freq_hz,
  input  logic [1:0]                    waveform,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dtws_pkg::MCLK_W-1:0]   mclk_hz,
  output logic                          word_strobe,
  output logic [dtws_pkg::WORD_W-1:0]   spi_word,
  output logic                          last,
  output logic                          reset_pin
);
  import dtws_pkg::*;

  logic                accept;
  logic [1:0]          gap;
  logic [MCLK_W-1:0]   div;
  logic [FCLAMP_W-1:0] freq_clamp;
  dtws_lane_t          lane [0:NCELL];

  assign accept    = start && !busy;
  assign busy      = (gap != 2'd0);
  assign cfg_ready = 1'b1;

  // Hold off new words while a set run still needs the result port.
  always_ff @(posedge clk) begin
    if (rst) begin
      gap <= 2'd0;
    end else if (accept && command == CMD_SET) begin
      gap <= SET_TAIL;
    end else if (gap != 2'd0) begin
      gap <= gap - 2'd1;
    end
  end

  // Master clock register; store zero as one so the divider never sees zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      div <= MCLK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      div <= (mclk_hz == '0) ? MCLK_ONE : mclk_hz;
    end
  end

  // Clamp the requested frequency to 1 Hz .. 10 MHz.
  always_comb begin
    if (freq_hz == '0) begin
      freq_clamp = FCLAMP_W'(1);
    end else if (freq_hz > FREQ_MAX) begin
      freq_clamp = FREQ_MAX[FCLAMP_W-1:0];
    end else begin
      freq_clamp = freq_hz[FCLAMP_W-1:0];
    end
  end

  // Chain entry: dividend is the clamped frequency shifted up by 28.
  always_comb begin
    lane[0].vld  = accept;
    lane[0].cmd  = command;
    lane[0].wave = waveform;
    lane[0].rem  = '0;
    lane[0].num  = {freq_clamp, {TUNE_W{1'b0}}};
  end

  // One restoring step per cell; the low 28 quotient bits leave the last cell.
  for (genvar gi = 0; gi < NCELL; gi++) begin : g_cell
    dtws_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .div      (div),
      .lane_in  (lane[gi]),
      .lane_out (lane[gi+1])
    );
  end

  dtws_emitter u_emitter (
    .clk         (clk),
    .rst         (rst),
    .lane_in     (lane[NCELL]),
    .word_strobe (word_strobe),
    .spi_word    (spi_word),
    .last        (last),
    .reset_pin   (reset_pin)
  );

  `ASSERT_PROP(a_set_holds_busy, clk, rst,
    (accept && command == CMD_SET) |=> busy ##1 busy ##1 busy)

endmodule
